// File: src/lifo_stack_unit_defines.svh
// ----------------------------------------------------------------------------
// LIFO stack unit assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_UNIT_DEFINES_SVH
`define LIFO_STACK_UNIT_DEFINES_SVH

// same-cycle implication
`define LSU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lifo_stack_unit check failed");

// next-cycle implication
`define LSU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lifo_stack_unit check failed");

`endif

// File: src/lsu_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack unit package
// Shared widths, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lsu_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STAT_W        = 2;
  localparam int DEFAULT_DEPTH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_PALL = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_POP  = 3'd3,
    CMD_SWAP = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_OUT,
    S_SW_RD1,
    S_SW_RD2,
    S_SW_WR1,
    S_SW_WR2
  } state_t;

endpackage

`default_nettype wire

// File: src/lifo_stack_unit.sv
// ----------------------------------------------------------------------------
// LIFO stack unit
// Data stack with push, print-all, peek, pop and swap under a small sequencer.
// Push, pop and any error leave the sequencer idle; only an error gives a beat,
// in the cycle after start. Peek: S_RD, S_OUT, result beat follows. Print-all:
// S_RD, S_OUT per entry. Swap: two reads, two writes, on the single read port.
// Reset (rst, synchronous) empties the stack and idles the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lifo_stack_unit_defines.svh"

module lifo_stack_unit #(
  parameter int DEPTH = lsu_pkg::DEFAULT_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [lsu_pkg::CMD_W-1:0]    cmd,
  input  wire logic [lsu_pkg::DATA_W-1:0]   push_value,
  output logic                              valid,
  output logic      [lsu_pkg::DATA_W-1:0]   out_value,
  output logic      [lsu_pkg::STAT_W-1:0]   status,
  output logic                              last
);
  import lsu_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   ptr, ptr_next;
  logic [IDX_W-1:0]   ptr_dec;
  cmd_t               cmd_q, cmd_q_next;
  logic [DATA_W-1:0]  tmp, tmp_next;
  logic               valid_next;
  logic [DATA_W-1:0]  out_value_next;
  status_t            status_next;
  logic               last_next;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [DATA_W-1:0]  wdata;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;

  logic               pop_take;

  lsu_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ptr_dec  = ptr - 1'b1;
  assign busy     = (state != S_IDLE);
  assign pop_take = start && !busy && (cmd == CMD_POP) && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      valid <= valid_next;
    end
    ptr       <= ptr_next;
    cmd_q     <= cmd_q_next;
    tmp       <= tmp_next;
    out_value <= out_value_next;
    status    <= status_next;
    last      <= last_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    cmd_q_next     = cmd_q;
    tmp_next       = tmp;
    valid_next     = 1'b0;
    out_value_next = '0;
    status_next    = ST_OK;
    last_next      = 1'b1;
    we             = 1'b0;
    waddr          = ptr;
    wdata          = push_value;
    raddr          = ptr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd_t'(cmd);
          ptr_next   = IDX_W'(count - 1'b1);
          unique case (cmd_t'(cmd))
            CMD_PUSH: begin
              if (count == CNT_W'(DEPTH)) begin
                valid_next  = 1'b1;
                status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = IDX_W'(count);
                count_next = count + 1'b1;
              end
            end
            CMD_PALL: begin
              if (count != '0) begin
                state_next = S_RD;
              end
            end
            CMD_PEEK: begin
              if (count == '0) begin
                valid_next  = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next = S_RD;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                valid_next  = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            CMD_SWAP: begin
              if (count < CNT_W'(2)) begin
                valid_next  = 1'b1;
                status_next = ST_SHORT;
              end else begin
                state_next = S_SW_RD1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        valid_next     = 1'b1;
        out_value_next = rdata;
        last_next      = (ptr == '0) || (cmd_q == CMD_PEEK);
        if (last_next) begin
          state_next = S_IDLE;
        end else begin
          ptr_next   = ptr_dec;
          state_next = S_RD;
        end
      end
      S_SW_RD1: begin
        state_next = S_SW_RD2;
      end
      S_SW_RD2: begin
        raddr      = ptr_dec;
        tmp_next   = rdata;
        state_next = S_SW_WR1;
      end
      S_SW_WR1: begin
        we         = 1'b1;
        wdata      = rdata;
        state_next = S_SW_WR2;
      end
      S_SW_WR2: begin
        we         = 1'b1;
        waddr      = ptr_dec;
        wdata      = tmp;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LSU_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `LSU_ASSERT_IMPL(a_err_zero, valid && (status != ST_OK), (out_value == '0) && last)
  `LSU_ASSERT_NEXT(a_pop_drops, pop_take, count == $past(count) - 1'b1)
  `LSU_ASSERT_IMPL(a_busy_no_write_past, busy && (count == '0), state == S_IDLE)

endmodule

`default_nettype wire

// File: src/lsu_ram.sv
// ----------------------------------------------------------------------------
// LIFO stack unit storage
// One write port and one registered read port over the stack entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_ram #(
  parameter int DEPTH = lsu_pkg::DEFAULT_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(DEPTH)-1:0]    waddr,
  input  wire logic [lsu_pkg::DATA_W-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0]    raddr,
  output logic      [lsu_pkg::DATA_W-1:0]  rdata
);
  import lsu_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
